@@ rtl/plr_pkg.sv @@
package plr_pkg;

   localparam int WORD_W      = 32;
   localparam int SAMPLE_W    = 16;
   localparam int LEVEL_W     = 8;
   localparam int FORMAT_W    = 3;
   localparam int CHAN_W      = 2;
   localparam int PHASE_W     = 23;
   localparam int COUNT_W     = 24;
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int MAX_OUT     = 16;
   localparam int OUT_COUNT_W = $clog2(MAX_OUT + 1);
   localparam int MAX_CHANNELS = 2;

   // one input frame in 7.16 phase units
   localparam logic [PHASE_W-1:0] ONE_FRAME = PHASE_W'(32'h0001_0000);

   // sample formats
   localparam logic [FORMAT_W-1:0] FMT_U8    = 3'd0;
   localparam logic [FORMAT_W-1:0] FMT_S16   = 3'd1;
   localparam logic [FORMAT_W-1:0] FMT_S24   = 3'd2;
   localparam logic [FORMAT_W-1:0] FMT_S32   = 3'd3;
   localparam logic [FORMAT_W-1:0] FMT_FLOAT = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PHASE_STEP    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_OUTPUT_TOTAL  = 2'd3;

   // register reset values
   localparam logic [FORMAT_W-1:0] RST_SAMPLE_FORMAT = FMT_S16;
   localparam logic [CHAN_W-1:0]   RST_CHANNEL_COUNT = 2'd1;
   localparam logic [PHASE_W-1:0]  RST_PHASE_STEP    = PHASE_W'(32'h0001_0000);
   localparam logic [COUNT_W-1:0]  RST_OUTPUT_TOTAL  = '0;

   typedef struct packed {
      logic [FORMAT_W-1:0] sample_format;
      logic [CHAN_W-1:0]   channel_count;
      logic [PHASE_W-1:0]  phase_step;
      logic [COUNT_W-1:0]  output_total;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic capture;     // transaction accepted, first word into converter
      logic conv_next;   // second word into converter
      logic conv_acc;    // hold first converted word
      logic conv_cur;    // form the frame average
      logic phase_fix;   // rebase phase when no interpolation runs
      logic mul;         // slope times phase
      logic put_i;       // emit interpolated sample
      logic put_t;       // emit tail sample
      logic finish;      // commit frame state
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic have_prev;
      logic last;
      logic interp_go;
      logic tail_go;
      logic more_i;
      logic more_t;
      logic out_free;
   } status_type;

endpackage

@@ rtl/plr_req_if.sv @@
interface plr_req_if
   import plr_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] first_channel_word;
   logic [WORD_W-1:0] second_channel_word;
   logic              final_frame;

   modport source (
      output valid, first_channel_word, second_channel_word, final_frame,
      input  ready
   );
   modport sink (
      input  valid, first_channel_word, second_channel_word, final_frame,
      output ready
   );
endinterface

@@ rtl/plr_rsp_if.sv @@
interface plr_rsp_if
   import plr_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] level;
   logic               run_end;
   logic               all_done;

   modport source (
      output valid, level, run_end, all_done,
      input  ready
   );
   modport sink (
      input  valid, level, run_end, all_done,
      output ready
   );
endinterface

@@ rtl/plr_conv.sv @@
module plr_conv
   import plr_pkg::*;
(
   input  logic                       clock,
   input  logic                       load,
   input  logic [WORD_W-1:0]          word,
   input  logic [FORMAT_W-1:0]        fmt,
   output logic signed [SAMPLE_W-1:0] q15
);

   logic [7:0]          expo;
   logic [22:0]         mant;
   logic                nan_w;
   logic                sat_w;
   logic                zero_w;
   logic [38:0]         prod_w;
   logic [5:0]          sh_w;
   logic [SAMPLE_W-1:0] fix_w;

   logic                float_ff;
   logic                nan_ff;
   logic                sat_ff;
   logic                zero_ff;
   logic                neg_ff;
   logic [5:0]          sh_ff;
   logic [38:0]         prod_ff;
   logic [SAMPLE_W-1:0] fix_ff;

   logic                top;
   logic [23:0]         q24;
   logic [14:0]         rem;
   logic [14:0]         half;
   logic                up;
   logic [24:0]         qr;
   logic [5:0]          amt;
   logic [24:0]         mag25;
   logic [SAMPLE_W-1:0] fmag;
   logic [SAMPLE_W-1:0] fval;

   // stage one: field split, mantissa times 32767, fixed formats
   assign expo   = word[30:23];
   assign mant   = word[22:0];
   assign nan_w  = (expo == 8'hFF) && (mant != '0);
   assign sat_w  = (expo >= 8'd127) && !nan_w;
   assign zero_w = (expo <= 8'd102);
   assign prod_w = 39'({1'b1, mant}) * 39'(15'd32767);
   assign sh_w   = 6'(8'd150 - expo);

   always_comb begin
      case (fmt)
         FMT_U8:  fix_w = {~word[7], word[6:0], 8'h00};
         FMT_S16: fix_w = word[15:0];
         FMT_S24: fix_w = word[23:8];
         FMT_S32: fix_w = word[31:16];
         default: fix_w = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         float_ff <= (fmt == FMT_FLOAT);
         nan_ff   <= nan_w;
         sat_ff   <= sat_w;
         zero_ff  <= zero_w;
         neg_ff   <= word[31];
         sh_ff    <= sh_w;
         prod_ff  <= prod_w;
         fix_ff   <= fix_w;
      end
   end

   // stage two: round product to 24 significant bits, then scale down
   assign top  = prod_ff[38];
   assign q24  = top ? prod_ff[38:15] : prod_ff[37:14];
   assign rem  = top ? prod_ff[14:0] : {1'b0, prod_ff[13:0]};
   assign half = top ? 15'h4000 : 15'h2000;
   assign up   = (rem > half) || ((rem == half) && q24[0]);
   assign qr   = {1'b0, q24} + 25'(up);
   assign amt  = sh_ff - (top ? 6'd15 : 6'd14);
   assign mag25 = qr >> amt;

   always_comb begin
      if (nan_ff || zero_ff) begin
         fmag = '0;
      end else if (sat_ff) begin
         fmag = 16'd32767;
      end else begin
         fmag = mag25[SAMPLE_W-1:0];
      end
      fval = neg_ff ? 16'(-fmag) : fmag;
      q15  = float_ff ? $signed(fval) : $signed(fix_ff);
   end

endmodule

@@ rtl/plr_dp.sv @@
module plr_dp
   import plr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  cmd_type             cmd,
   output status_type          st,
   input  logic [WORD_W-1:0]   req_first_channel_word,
   input  logic [WORD_W-1:0]   req_second_channel_word,
   input  logic                req_final_frame,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [LEVEL_W-1:0]  rsp_level,
   output logic                rsp_run_end,
   output logic                rsp_all_done
);

   logic [WORD_W-1:0]          word1_ff;
   logic                       last_ff;
   logic signed [SAMPLE_W-1:0] acc_ff;
   logic signed [SAMPLE_W-1:0] cur_ff;
   logic signed [SAMPLE_W-1:0] cur_in;
   logic signed [SAMPLE_W-1:0] prev_ff;
   logic                       have_prev_ff;
   logic [PHASE_W-1:0]         phase_ff;
   logic [PHASE_W-1:0]         phase_in;
   logic [COUNT_W-1:0]         emitted_ff;
   logic [OUT_COUNT_W-1:0]     n_ff;
   logic signed [33:0]         prod_ff;

   logic                       rsp_valid_ff;
   logic [LEVEL_W-1:0]         level_ff;
   logic [LEVEL_W-1:0]         level_in;
   logic                       run_end_ff;
   logic                       run_end_in;
   logic                       all_done_ff;

   logic [WORD_W-1:0]          conv_word;
   logic signed [SAMPLE_W-1:0] q15;
   logic                       two_ch;
   logic signed [16:0]         sum;
   logic signed [16:0]         sum_adj;
   logic signed [16:0]         diff;
   logic signed [17:0]         slope_part;
   logic signed [18:0]         v;
   logic [COUNT_W-1:0]         emitted_inc;
   logic                       inc_below;
   logic                       n_room;
   logic [PHASE_W:0]           ph_sum;
   logic                       ph_sum_in_frame;
   logic                       put;

   assign conv_word = cmd.capture ? req_first_channel_word : word1_ff;

   plr_conv u_conv (
      .clock (clock),
      .load  (cmd.capture || cmd.conv_next),
      .word  (conv_word),
      .fmt   (cfg.sample_format),
      .q15   (q15)
   );

   // channel counts of two and three both average two channels
   assign two_ch  = (MAX_CHANNELS > 1) && cfg.channel_count[1];
   assign sum     = 17'(acc_ff) + 17'(q15);
   assign sum_adj = sum + 17'(sum[16]);
   assign cur_in  = two_ch ? sum_adj[16:1] : acc_ff;

   assign emitted_inc     = emitted_ff + 1'b1;
   assign inc_below       = emitted_inc < cfg.output_total;
   assign n_room          = n_ff < OUT_COUNT_W'(MAX_OUT - 1);
   assign ph_sum          = {1'b0, phase_ff} + {1'b0, cfg.phase_step};
   assign ph_sum_in_frame = ph_sum < {1'b0, ONE_FRAME};
   assign put             = cmd.put_i || cmd.put_t;

   assign st.have_prev = have_prev_ff;
   assign st.last      = last_ff;
   assign st.interp_go = have_prev_ff && (phase_ff < ONE_FRAME)
                         && (emitted_ff < cfg.output_total);
   assign st.tail_go   = last_ff && (emitted_ff < cfg.output_total);
   assign st.more_i    = ph_sum_in_frame && inc_below && n_room;
   assign st.more_t    = last_ff && inc_below && n_room;
   assign st.out_free  = !rsp_valid_ff || rsp_ready;

   // interpolation: prev + floor(slope * frac / 65536), biased and clamped
   assign diff       = 17'(cur_ff) - 17'(prev_ff);
   assign slope_part = 18'(prod_ff >>> 16);
   assign v          = 19'(prev_ff) + 19'(slope_part) + 19'sd32768;

   always_comb begin
      if (cmd.put_i) begin
         if (v < 0) begin
            level_in = '0;
         end else if (v[18:8] > 11'd255) begin
            level_in = 8'hFF;
         end else begin
            level_in = v[15:8];
         end
         run_end_in = !(st.more_i || st.more_t);
      end else begin
         level_in   = {~cur_ff[15], cur_ff[14:8]};
         run_end_in = !st.more_t;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (cmd.put_i) begin
         if (st.more_i) begin
            phase_in = ph_sum[PHASE_W-1:0];
         end else if (!ph_sum_in_frame) begin
            phase_in = PHASE_W'(ph_sum - {1'b0, ONE_FRAME});
         end else begin
            phase_in = '0;
         end
      end else if (cmd.phase_fix) begin
         phase_in = (phase_ff >= ONE_FRAME) ? phase_ff - ONE_FRAME : '0;
      end else if (cmd.finish && last_ff) begin
         // end of sound, next frame starts on the grid
         phase_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         word1_ff <= req_second_channel_word;
         last_ff  <= req_final_frame;
      end
      if (cmd.conv_acc) begin
         acc_ff <= q15;
      end
      if (cmd.conv_cur) begin
         cur_ff <= cur_in;
      end
      if (cmd.mul) begin
         prod_ff <= diff * $signed({1'b0, phase_ff[15:0]});
      end
      if (put) begin
         level_ff    <= level_in;
         run_end_ff  <= run_end_in;
         all_done_ff <= (emitted_inc == cfg.output_total);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         phase_ff     <= '0;
         emitted_ff   <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (cmd.capture) begin
            n_ff <= '0;
         end else if (put) begin
            n_ff <= n_ff + 1'b1;
         end
         if (put) begin
            emitted_ff <= emitted_inc;
         end else if (cmd.finish && last_ff) begin
            emitted_ff <= '0;
         end
         if (cmd.finish) begin
            prev_ff      <= cur_ff;
            have_prev_ff <= !last_ff;
         end
         if (put) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_level    = level_ff;
   assign rsp_run_end  = run_end_ff;
   assign rsp_all_done = all_done_ff;

   a_put_fills_out: assert property (@(posedge clock) disable iff (reset)
      put |=> rsp_valid_ff)
      else $error("emitted sample did not reach output register");

   a_put_when_free: assert property (@(posedge clock) disable iff (reset)
      put |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten while held");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= OUT_COUNT_W'(MAX_OUT))
      else $error("per-frame output count past cap");

endmodule

@@ rtl/plr_ctrl.sv @@
module plr_ctrl
   import plr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type st,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b000_0001,
      ST_CV1    = 7'b000_0010,
      ST_CV2    = 7'b000_0100,
      ST_MUL    = 7'b000_1000,
      ST_PUT_I  = 7'b001_0000,
      ST_PUT_T  = 7'b010_0000,
      ST_FINISH = 7'b100_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CV1;
            end
         end
         ST_CV1: begin
            cmd.conv_acc  = 1'b1;
            cmd.conv_next = 1'b1;
            state_in      = ST_CV2;
         end
         ST_CV2: begin
            cmd.conv_cur = 1'b1;
            if (st.interp_go) begin
               state_in = ST_MUL;
            end else begin
               cmd.phase_fix = 1'b1;
               state_in      = st.tail_go ? ST_PUT_T : ST_FINISH;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_PUT_I;
         end
         ST_PUT_I: begin
            if (st.out_free) begin
               cmd.put_i = 1'b1;
               if (st.more_i) begin
                  state_in = ST_MUL;
               end else if (st.more_t) begin
                  state_in = ST_PUT_T;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_PUT_T: begin
            if (st.out_free) begin
               cmd.put_t = 1'b1;
               state_in  = st.more_t ? ST_PUT_T : ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_CV1))
      else $error("accepted frame did not start conversion");

   a_put_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUT_I && !st.out_free) |=> (state_ff == ST_PUT_I))
      else $error("interpolated sample dropped under backpressure");

   a_interp_needs_prev: assert property (@(posedge clock) disable iff (reset)
      cmd.put_i |-> st.have_prev)
      else $error("interpolation without a previous frame");

endmodule

@@ rtl/pcm_linear_resampler_u8.sv @@
// sequence: after a transaction is accepted, its first interpolated sample reaches the
//   output register through two-step word conversion, slope multiply and output load;
//   a frame that only has tail samples loads its first one right after conversion
// flow: a slope multiply on the shared multiplier and an output load per interpolated
//   sample, then tail loads; loads wait on a held output; next frame only after commit
// reset: synchronous active high, restores register defaults and starts a new sound
module pcm_linear_resampler_u8
   import plr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   plr_req_if.sink                req_bus,
   plr_rsp_if.source              rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type st;

   // configuration registers; the user must write them only between frames, not enforced here
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_format <= RST_SAMPLE_FORMAT;
         cfg_ff.channel_count <= RST_CHANNEL_COUNT;
         cfg_ff.phase_step    <= RST_PHASE_STEP;
         cfg_ff.output_total  <= RST_OUTPUT_TOTAL;
      end else if (csr_we) begin
         case (csr_index)
            REG_SAMPLE_FORMAT: cfg_ff.sample_format <= csr_wdata[FORMAT_W-1:0];
            REG_CHANNEL_COUNT: cfg_ff.channel_count <= csr_wdata[CHAN_W-1:0];
            REG_PHASE_STEP:    cfg_ff.phase_step    <= csr_wdata[PHASE_W-1:0];
            REG_OUTPUT_TOTAL:  cfg_ff.output_total  <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer: conversion, per-sample multiply/emit loop, tail, commit
   plr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .st        (st),
      .cmd       (cmd)
   );

   // datapath holds frame state, phase, counts and the output register
   plr_dp u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cfg                     (cfg_ff),
      .cmd                     (cmd),
      .st                      (st),
      .req_first_channel_word  (req_bus.first_channel_word),
      .req_second_channel_word (req_bus.second_channel_word),
      .req_final_frame         (req_bus.final_frame),
      .rsp_valid               (rsp_bus.valid),
      .rsp_ready               (rsp_bus.ready),
      .rsp_level               (rsp_bus.level),
      .rsp_run_end             (rsp_bus.run_end),
      .rsp_all_done            (rsp_bus.all_done)
   );

endmodule
